>>> hw/rtl/ehtbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ehtbl_pkg;

    // table geometry
    localparam int MAX_DEPTH = 8;
    localparam int MAX_SLOTS = 4;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int DIR_N     = 1 << MAX_DEPTH;
    localparam int DIR_W     = MAX_DEPTH;
    localparam int DIRP_W    = DIR_W + 1;
    localparam int LD_W      = $clog2(MAX_DEPTH + 1);
    localparam int PB_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CAP_W     = $clog2(MAX_SLOTS + 1);

    // port field widths
    localparam int ACT_W = 2;
    localparam int IDX_W = 8;
    localparam int CFG_W = 3;
    localparam int LDO_W = 5;
    localparam int GD_W  = 4;
    localparam int BC_W  = 9;

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(4);

    typedef enum logic [ACT_W-1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR_RD,
        ST_BKT_RD,
        ST_EVAL,
        ST_DOUBLE,
        ST_SPLIT,
        ST_REPOINT,
        ST_WRBACK,
        ST_DONE
    } t_state;

    // one bucket row of the bucket memory
    typedef struct packed {
        logic [LD_W-1:0]                  ld;
        logic [MAX_SLOTS-1:0]             valid;
        logic [MAX_SLOTS-1:0][KEY_W-1:0]  key;
        logic [MAX_SLOTS-1:0][VAL_W-1:0]  val;
    } t_row;

    localparam int ROW_W = LD_W + MAX_SLOTS * (1 + KEY_W + VAL_W);

    // bucket evaluation results handed to the sequencer
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] hit_value;
        logic             fits;
        logic             found;
        logic [PB_W-1:0]  p;
        t_row             upd_row;
        t_row             lo_row;
        t_row             hi_row;
    } t_eval;

    function automatic logic [DIR_W-1:0] low_mask(input logic [LD_W-1:0] n);
        logic [DIRP_W-1:0] t;
        t = DIRP_W'(1) << n;
        return DIR_W'(t - 1'b1);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ehtbl_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface ehtbl_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ehtbl_pkg::ACT_W-1:0]          action;
    logic signed [ehtbl_pkg::KEY_W-1:0]   key;
    logic signed [ehtbl_pkg::VAL_W-1:0]   value_in;
    logic [ehtbl_pkg::IDX_W-1:0]          dir_index;

    modport source (output valid, action, key, value_in, dir_index, input ready);
    modport sink   (input valid, action, key, value_in, dir_index, output ready);
endinterface

// response channel
interface ehtbl_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic signed [ehtbl_pkg::VAL_W-1:0]   value_out;
    logic                                 status;
    logic signed [ehtbl_pkg::LDO_W-1:0]   local_depth;
    logic [ehtbl_pkg::GD_W-1:0]           global_depth;
    logic [ehtbl_pkg::BC_W-1:0]           bucket_count;

    modport source (output valid, hit, value_out, status, local_depth, global_depth,
                    bucket_count, input ready);
    modport sink   (input valid, hit, value_out, status, local_depth, global_depth,
                    bucket_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ehtbl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ehtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output      logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port, read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/ehtbl_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module ehtbl_eval (
    input  wire ehtbl_pkg::t_row                 i_row,
    input  wire logic [ehtbl_pkg::KEY_W-1:0]     i_key,
    input  wire logic [ehtbl_pkg::VAL_W-1:0]     i_value,
    input  wire logic [ehtbl_pkg::CFG_W-1:0]     i_slots,
    input  wire ehtbl_pkg::t_action              i_action,
    output      ehtbl_pkg::t_eval                o_ev
);

    logic [ehtbl_pkg::MAX_SLOTS-1:0] match;
    logic [ehtbl_pkg::MAX_SLOTS-1:0] hit_oh;
    logic [ehtbl_pkg::MAX_SLOTS-1:0] free_oh;
    logic [ehtbl_pkg::MAX_SLOTS-1:0] lo_valid;
    logic [ehtbl_pkg::MAX_SLOTS-1:0] hi_valid;
    logic [ehtbl_pkg::MAX_SLOTS-1:0] new_oh;
    logic [ehtbl_pkg::CAP_W-1:0]     cap;
    logic [ehtbl_pkg::CAP_W:0]       n_cnt;
    logic [ehtbl_pkg::DIR_W-1:0]     diff;
    logic [ehtbl_pkg::DIR_W-1:0]     klow;
    logic [ehtbl_pkg::DIR_W-1:0]     hlow;
    logic [ehtbl_pkg::PB_W-1:0]      p;
    logic                            new_bit;
    logic                            taken;
    logic                            slot_taken;
    logic [ehtbl_pkg::VAL_W-1:0]     hit_value;
    ehtbl_pkg::t_row                 upd;
    ehtbl_pkg::t_row                 lo;
    ehtbl_pkg::t_row                 hi;

    assign hlow = i_key[ehtbl_pkg::DIR_W-1:0];

    // key compare, first hit, first free slot
    always_comb begin
        hit_value = '0;
        taken     = 1'b0;
        hit_oh    = '0;
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            match[s] = i_row.valid[s] && (i_row.key[s] == i_key);
            if (match[s] && !taken) begin
                hit_oh[s] = 1'b1;
                taken     = 1'b1;
                hit_value = i_row.val[s];
            end
        end
        taken   = 1'b0;
        free_oh = '0;
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            if (!i_row.valid[s] && !taken) begin
                free_oh[s] = 1'b1;
                taken      = 1'b1;
            end
        end
    end

    // effective capacity and fit check
    always_comb begin
        if (i_slots == '0) begin
            cap = ehtbl_pkg::CAP_W'(1);
        end else if (int'(i_slots) > ehtbl_pkg::MAX_SLOTS) begin
            cap = ehtbl_pkg::CAP_W'(ehtbl_pkg::MAX_SLOTS);
        end else begin
            cap = ehtbl_pkg::CAP_W'(i_slots);
        end
        n_cnt = (ehtbl_pkg::CAP_W + 1)'($countones(i_row.valid));
    end

    // first hash bit at or above local depth that separates the pairs
    always_comb begin
        diff = '0;
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            if (i_row.valid[s]) begin
                diff = diff | (i_row.key[s][ehtbl_pkg::DIR_W-1:0] ^ hlow);
            end
        end
        diff = diff & ~ehtbl_pkg::low_mask(i_row.ld);
        p    = '0;
        for (int i = ehtbl_pkg::DIR_W - 1; i >= 0; i--) begin
            if (diff[i]) begin
                p = ehtbl_pkg::PB_W'(i);
            end
        end
        new_bit = hlow[p];
    end

    // updated row for remove and plain insert
    always_comb begin
        upd = i_row;
        if (i_action == ehtbl_pkg::ACT_REMOVE) begin
            upd.valid = i_row.valid & ~hit_oh;
        end else if (|hit_oh) begin
            for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
                if (hit_oh[s]) begin
                    upd.val[s] = i_value;
                end
            end
        end else begin
            for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
                if (free_oh[s]) begin
                    upd.valid[s] = 1'b1;
                    upd.key[s]   = i_key;
                    upd.val[s]   = i_value;
                end
            end
        end
    end

    // split of the overflowing pairs into the two halves
    always_comb begin
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            klow        = i_row.key[s][ehtbl_pkg::DIR_W-1:0];
            lo_valid[s] = i_row.valid[s] && !klow[p];
            hi_valid[s] = i_row.valid[s] && klow[p];
        end
        slot_taken = 1'b0;
        new_oh     = '0;
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            if (!(new_bit ? hi_valid[s] : lo_valid[s]) && !slot_taken) begin
                new_oh[s]  = 1'b1;
                slot_taken = 1'b1;
            end
        end
        lo       = i_row;
        hi       = i_row;
        lo.ld    = ehtbl_pkg::LD_W'(p) + 1'b1;
        hi.ld    = ehtbl_pkg::LD_W'(p) + 1'b1;
        lo.valid = lo_valid;
        hi.valid = hi_valid;
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            if (new_oh[s] && !new_bit) begin
                lo.valid[s] = 1'b1;
                lo.key[s]   = i_key;
                lo.val[s]   = i_value;
            end
            if (new_oh[s] && new_bit) begin
                hi.valid[s] = 1'b1;
                hi.key[s]   = i_key;
                hi.val[s]   = i_value;
            end
        end
    end

    assign o_ev.hit       = |hit_oh;
    assign o_ev.hit_value = hit_value;
    assign o_ev.fits      = ((n_cnt + 1'b1) <= {1'b0, cap}) && !(&i_row.valid);
    assign o_ev.found     = |diff;
    assign o_ev.p         = p;
    assign o_ev.upd_row   = upd;
    assign o_ev.lo_row    = lo;
    assign o_ev.hi_row    = hi;

endmodule

`default_nettype wire

>>> hw/rtl/extendible_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Extendible hash table of 32-bit key/value pairs.
// Requests come in on i_req (action, key, value_in, dir_index), one response per
// request leaves on o_rsp; both channels move on valid and ready high together.
// The bucket size register is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle, the block itself does not enforce this. One
// request is in work at a time; i_req.ready is high only when the sequencer is
// idle. Find, remove, query and inserts that do not split pass through directory
// read, bucket read, evaluate and write back, then the response register. An
// insert that splits first doubles the directory until its depth passes the
// separating bit, copying each entry into the new upper half, then per new bucket
// writes one row and repoints its directory entries, then writes back the old
// bucket; the directory and bucket memories have one write and one read port
// each. After reset a clearing pass writes every directory entry and bucket row;
// requests are held off until it ends.
// The response sits in an output register; the next request is taken while it
// waits, and that request waits before its response until o_rsp.ready frees it.
module extendible_hash_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ehtbl_pkg::CFG_W-1:0]     i_cfg_wdata,
    ehtbl_req_if.sink                            i_req,
    ehtbl_rsp_if.source                          o_rsp
);

    ehtbl_pkg::t_state                 r_state, n_state;
    ehtbl_pkg::t_action                r_act, n_act;
    logic [ehtbl_pkg::KEY_W-1:0]       r_key, n_key;
    logic [ehtbl_pkg::VAL_W-1:0]       r_val, n_val;
    logic [ehtbl_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [ehtbl_pkg::DIR_W-1:0]       r_b, n_b;
    logic [ehtbl_pkg::LD_W-1:0]        r_depth, n_depth;
    logic [ehtbl_pkg::DIRP_W-1:0]      r_used, n_used;
    logic [ehtbl_pkg::CFG_W-1:0]       r_slots;
    logic [ehtbl_pkg::LD_W-1:0]        r_d, n_d;
    logic [ehtbl_pkg::DIR_W-1:0]       r_addr, n_addr;
    logic [ehtbl_pkg::DIRP_W-1:0]      r_cnt, n_cnt;
    logic                              r_pend, n_pend;
    logic [ehtbl_pkg::DIR_W-1:0]       r_waddr, n_waddr;
    logic                              r_hit, n_hit;
    logic [ehtbl_pkg::VAL_W-1:0]       r_vout, n_vout;
    logic                              r_status, n_status;
    logic [ehtbl_pkg::LDO_W-1:0]       r_ld, n_ld;
    logic                              r_ov, n_ov;
    logic                              r_o_hit, n_o_hit;
    logic [ehtbl_pkg::VAL_W-1:0]       r_o_vout, n_o_vout;
    logic                              r_o_status, n_o_status;
    logic [ehtbl_pkg::LDO_W-1:0]       r_o_ld, n_o_ld;
    logic [ehtbl_pkg::GD_W-1:0]        r_o_gd, n_o_gd;
    logic [ehtbl_pkg::BC_W-1:0]        r_o_bc, n_o_bc;

    logic                              dir_we, dir_re;
    logic [ehtbl_pkg::DIR_W-1:0]       dir_waddr, dir_wdata, dir_raddr, dir_rdata;
    logic                              bkt_we, bkt_re;
    logic [ehtbl_pkg::DIR_W-1:0]       bkt_waddr, bkt_raddr;
    ehtbl_pkg::t_row                   bkt_wdata, bkt_row;
    logic [ehtbl_pkg::ROW_W-1:0]       bkt_rdata;
    ehtbl_pkg::t_eval                  ev;

    logic                              req_acc, out_free;
    logic [ehtbl_pkg::LD_W-1:0]        p_ld;
    logic [ehtbl_pkg::DIRP_W-1:0]      old_n, limit, stride, next_addr;
    logic                              last_step, in_range;
    logic [ehtbl_pkg::DIR_W-1:0]       hbits, pattern, d_oh;
    ehtbl_pkg::t_row                   empty_row;

    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_rsp.ready;
    assign bkt_row  = ehtbl_pkg::t_row'(bkt_rdata);
    assign p_ld     = ehtbl_pkg::LD_W'(ev.p);

    // directory and bucket memories
    ehtbl_ram #(.WIDTH(ehtbl_pkg::DIR_W), .DEPTH(ehtbl_pkg::DIR_N)) u_dir (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_re    (dir_re),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    ehtbl_ram #(.WIDTH(ehtbl_pkg::ROW_W), .DEPTH(ehtbl_pkg::DIR_N)) u_bkt (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (ehtbl_pkg::ROW_W'(bkt_wdata)),
        .i_re    (bkt_re),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    // bucket evaluation on the row read back
    ehtbl_eval u_eval (
        .i_row    (bkt_row),
        .i_key    (r_key),
        .i_value  (r_val),
        .i_slots  (r_slots),
        .i_action (r_act),
        .o_ev     (ev)
    );

    // split and directory walk arithmetic
    always_comb begin
        old_n     = ehtbl_pkg::DIRP_W'(1) << r_depth;
        limit     = old_n;
        stride    = ehtbl_pkg::DIRP_W'(1) << (r_d + 1'b1);
        next_addr = {1'b0, r_addr} + stride;
        last_step = (r_d == p_ld);
        hbits     = r_key[ehtbl_pkg::DIR_W-1:0];
        d_oh      = ehtbl_pkg::DIR_W'(1) << r_d;
        pattern   = hbits & ehtbl_pkg::low_mask(r_d);
        if (last_step || !(|(hbits & d_oh))) begin
            pattern = pattern | d_oh;
        end
        in_range      = {1'b0, r_idx} < old_n;
        empty_row     = '0;
        empty_row.ld  = r_d + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ehtbl_pkg::ST_CLEAR: begin
                if (r_cnt == ehtbl_pkg::DIRP_W'(ehtbl_pkg::DIR_N - 1)) begin
                    n_state = ehtbl_pkg::ST_IDLE;
                end
            end
            ehtbl_pkg::ST_IDLE: begin
                if (req_acc) begin
                    n_state = ehtbl_pkg::ST_DIR_RD;
                end
            end
            ehtbl_pkg::ST_DIR_RD: n_state = ehtbl_pkg::ST_BKT_RD;
            ehtbl_pkg::ST_BKT_RD: n_state = ehtbl_pkg::ST_EVAL;
            ehtbl_pkg::ST_EVAL: begin
                if (r_act == ehtbl_pkg::ACT_INSERT && !ev.hit && !ev.fits && ev.found) begin
                    n_state = (r_depth <= p_ld) ? ehtbl_pkg::ST_DOUBLE : ehtbl_pkg::ST_SPLIT;
                end else begin
                    n_state = ehtbl_pkg::ST_DONE;
                end
            end
            ehtbl_pkg::ST_DOUBLE: begin
                if (r_cnt == old_n && !r_pend && (r_depth + 1'b1 > p_ld)) begin
                    n_state = ehtbl_pkg::ST_SPLIT;
                end
            end
            ehtbl_pkg::ST_SPLIT: n_state = ehtbl_pkg::ST_REPOINT;
            ehtbl_pkg::ST_REPOINT: begin
                if (next_addr >= limit) begin
                    n_state = last_step ? ehtbl_pkg::ST_WRBACK : ehtbl_pkg::ST_SPLIT;
                end
            end
            ehtbl_pkg::ST_WRBACK: n_state = ehtbl_pkg::ST_DONE;
            ehtbl_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ehtbl_pkg::ST_IDLE;
                end
            end
            default: n_state = ehtbl_pkg::ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        dir_we    = 1'b0;
        dir_waddr = '0;
        dir_wdata = '0;
        dir_re    = 1'b0;
        dir_raddr = '0;
        bkt_we    = 1'b0;
        bkt_waddr = '0;
        bkt_wdata = '0;
        bkt_re    = 1'b0;
        bkt_raddr = '0;
        case (r_state)
            ehtbl_pkg::ST_CLEAR: begin
                dir_we    = 1'b1;
                dir_waddr = r_cnt[ehtbl_pkg::DIR_W-1:0];
                bkt_we    = 1'b1;
                bkt_waddr = r_cnt[ehtbl_pkg::DIR_W-1:0];
            end
            ehtbl_pkg::ST_DIR_RD: begin
                dir_re = 1'b1;
                if (r_act == ehtbl_pkg::ACT_QUERY) begin
                    dir_raddr = ehtbl_pkg::DIR_W'(r_idx);
                end else begin
                    dir_raddr = hbits & ehtbl_pkg::low_mask(r_depth);
                end
            end
            ehtbl_pkg::ST_BKT_RD: begin
                bkt_re    = 1'b1;
                bkt_raddr = dir_rdata;
            end
            ehtbl_pkg::ST_EVAL: begin
                if ((r_act == ehtbl_pkg::ACT_REMOVE && ev.hit) ||
                    (r_act == ehtbl_pkg::ACT_INSERT && (ev.hit || ev.fits))) begin
                    bkt_we    = 1'b1;
                    bkt_waddr = r_b;
                    bkt_wdata = ev.upd_row;
                end
            end
            ehtbl_pkg::ST_DOUBLE: begin
                if (r_cnt < old_n) begin
                    dir_re    = 1'b1;
                    dir_raddr = r_cnt[ehtbl_pkg::DIR_W-1:0];
                end
                if (r_pend) begin
                    dir_we    = 1'b1;
                    dir_waddr = r_waddr;
                    dir_wdata = dir_rdata;
                end
            end
            ehtbl_pkg::ST_SPLIT: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_used[ehtbl_pkg::DIR_W-1:0];
                bkt_wdata = last_step ? ev.hi_row : empty_row;
            end
            ehtbl_pkg::ST_REPOINT: begin
                dir_we    = 1'b1;
                dir_waddr = r_addr;
                dir_wdata = r_used[ehtbl_pkg::DIR_W-1:0];
            end
            ehtbl_pkg::ST_WRBACK: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_b;
                bkt_wdata = ev.lo_row;
            end
            default: begin
                dir_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_act      = r_act;
        n_key      = r_key;
        n_val      = r_val;
        n_idx      = r_idx;
        n_b        = r_b;
        n_depth    = r_depth;
        n_used     = r_used;
        n_d        = r_d;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_pend     = r_pend;
        n_waddr    = r_waddr;
        n_hit      = r_hit;
        n_vout     = r_vout;
        n_status   = r_status;
        n_ld       = r_ld;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_hit    = r_o_hit;
        n_o_vout   = r_o_vout;
        n_o_status = r_o_status;
        n_o_ld     = r_o_ld;
        n_o_gd     = r_o_gd;
        n_o_bc     = r_o_bc;
        case (r_state)
            ehtbl_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
            end
            ehtbl_pkg::ST_IDLE: begin
                if (req_acc) begin
                    n_act = ehtbl_pkg::t_action'(i_req.action);
                    n_key = unsigned'(i_req.key);
                    n_val = unsigned'(i_req.value_in);
                    n_idx = i_req.dir_index;
                end
            end
            ehtbl_pkg::ST_BKT_RD: begin
                n_b = dir_rdata;
            end
            ehtbl_pkg::ST_EVAL: begin
                n_hit    = (r_act == ehtbl_pkg::ACT_FIND || r_act == ehtbl_pkg::ACT_REMOVE)
                           && ev.hit;
                n_vout   = (r_act == ehtbl_pkg::ACT_FIND && ev.hit) ? ev.hit_value : '0;
                n_status = (r_act == ehtbl_pkg::ACT_INSERT) && !ev.hit && !ev.fits
                           && !ev.found;
                if (r_act == ehtbl_pkg::ACT_QUERY) begin
                    n_ld = in_range ? ehtbl_pkg::LDO_W'(bkt_row.ld) : '1;
                end else begin
                    n_ld = '0;
                end
                n_d    = bkt_row.ld;
                n_cnt  = '0;
                n_pend = 1'b0;
            end
            ehtbl_pkg::ST_DOUBLE: begin
                if (r_cnt < old_n) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_pend  = 1'b1;
                    n_waddr = r_cnt[ehtbl_pkg::DIR_W-1:0] + old_n[ehtbl_pkg::DIR_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_cnt == old_n && !r_pend) begin
                    n_depth = r_depth + 1'b1;
                    n_cnt   = '0;
                end
            end
            ehtbl_pkg::ST_SPLIT: begin
                n_addr = pattern;
            end
            ehtbl_pkg::ST_REPOINT: begin
                n_addr = next_addr[ehtbl_pkg::DIR_W-1:0];
                if (next_addr >= limit) begin
                    n_used = r_used + 1'b1;
                    n_d    = r_d + 1'b1;
                end
            end
            ehtbl_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_hit    = r_hit;
                    n_o_vout   = r_vout;
                    n_o_status = r_status;
                    n_o_ld     = r_ld;
                    n_o_gd     = ehtbl_pkg::GD_W'(r_depth);
                    n_o_bc     = ehtbl_pkg::BC_W'(r_used);
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ehtbl_pkg::ST_CLEAR;
            r_depth <= '0;
            r_used  <= ehtbl_pkg::DIRP_W'(1);
            r_slots <= ehtbl_pkg::SLOTS_RESET;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_used  <= n_used;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_slots <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_key      <= n_key;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_b        <= n_b;
        r_d        <= n_d;
        r_addr     <= n_addr;
        r_waddr    <= n_waddr;
        r_hit      <= n_hit;
        r_vout     <= n_vout;
        r_status   <= n_status;
        r_ld       <= n_ld;
        r_o_hit    <= n_o_hit;
        r_o_vout   <= n_o_vout;
        r_o_status <= n_o_status;
        r_o_ld     <= n_o_ld;
        r_o_gd     <= n_o_gd;
        r_o_bc     <= n_o_bc;
    end

    assign i_req.ready        = (r_state == ehtbl_pkg::ST_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.hit          = r_o_hit;
    assign o_rsp.value_out    = signed'(r_o_vout);
    assign o_rsp.status       = r_o_status;
    assign o_rsp.local_depth  = signed'(r_o_ld);
    assign o_rsp.global_depth = r_o_gd;
    assign o_rsp.bucket_count = r_o_bc;

`ifndef SYNTH
    // bucket count stays within the directory size
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) && (r_used <= ehtbl_pkg::DIRP_W'(ehtbl_pkg::DIR_N)))
        else $error("bucket count out of range");

    // global depth never passes the limit
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= ehtbl_pkg::LD_W'(ehtbl_pkg::MAX_DEPTH))
        else $error("global depth above limit");

    // repoint writes stay inside the live directory
    a_repoint_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ehtbl_pkg::ST_REPOINT) |-> ({1'b0, r_addr} < limit))
        else $error("repoint beyond directory");

    // bucket count moves only at the end of a repoint walk
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> ($past(r_state) == ehtbl_pkg::ST_REPOINT))
        else $error("bucket count changed outside a split");

    // a split only runs once the directory is deep enough
    a_split_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ehtbl_pkg::ST_SPLIT) |-> (r_depth > r_d))
        else $error("split above global depth");
`endif

endmodule

`default_nettype wire

>>> tb/ehtbl_checker.sv
`timescale 1ns / 1ps

// watches both channels and the slot register port, predicts every response
module ehtbl_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ehtbl_pkg::CFG_W-1:0] i_cfg_wdata,
    ehtbl_req_if                             i_req,
    ehtbl_rsp_if                             i_rsp,
    output int                               o_fail_count
);

    typedef struct packed {
        logic                        hit;
        logic [ehtbl_pkg::VAL_W-1:0] value_out;
        logic                        status;
        logic [ehtbl_pkg::LDO_W-1:0] local_depth;
        logic [ehtbl_pkg::GD_W-1:0]  global_depth;
        logic [ehtbl_pkg::BC_W-1:0]  bucket_count;
    } t_rsp;

    // shadow copy of the table
    int                          dir_bkt [ehtbl_pkg::DIR_N];
    int                          bkt_depth [ehtbl_pkg::DIR_N];
    logic [ehtbl_pkg::KEY_W-1:0] slot_k [ehtbl_pkg::DIR_N*ehtbl_pkg::MAX_SLOTS];
    logic [ehtbl_pkg::VAL_W-1:0] slot_v [ehtbl_pkg::DIR_N*ehtbl_pkg::MAX_SLOTS];
    bit                          slot_used [ehtbl_pkg::DIR_N*ehtbl_pkg::MAX_SLOTS];
    int                          gdepth;
    int                          nbuckets;
    int                          slots_reg;

    t_rsp pending_rsp[$];

    function automatic int dmask(int n);
        return (1 << n) - 1;
    endfunction

    function automatic int lookup(int b, logic [ehtbl_pkg::KEY_W-1:0] h);
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            if (slot_used[b*ehtbl_pkg::MAX_SLOTS+s] && slot_k[b*ehtbl_pkg::MAX_SLOTS+s] == h)
                return b*ehtbl_pkg::MAX_SLOTS + s;
        end
        return -1;
    endfunction

    function automatic void wipe_bucket(int b);
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) slot_used[b*ehtbl_pkg::MAX_SLOTS+s] = 0;
    endfunction

    function automatic void redirect(int pattern, int d, int b);
        for (int i = 0; i < (1 << gdepth); i++) begin
            if ((i & dmask(d)) == pattern) dir_bkt[i] = b;
        end
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < ehtbl_pkg::DIR_N; i++) begin
            dir_bkt[i] = 0;
            bkt_depth[i] = 0;
        end
        for (int i = 0; i < ehtbl_pkg::DIR_N*ehtbl_pkg::MAX_SLOTS; i++) slot_used[i] = 0;
        gdepth = 0;
        nbuckets = 1;
        slots_reg = 4;
    endfunction

    // store a pair, splitting the bucket as needed; returns 1 when refused
    function automatic bit store_pair(logic [ehtbl_pkg::KEY_W-1:0] h,
                                      logic [ehtbl_pkg::VAL_W-1:0] val);
        logic [ehtbl_pkg::KEY_W-1:0] ek [ehtbl_pkg::MAX_SLOTS+1];
        logic [ehtbl_pkg::VAL_W-1:0] ev [ehtbl_pkg::MAX_SLOTS+1];
        int b, n, free_i, cap, ld0, p, base, nb, v, idx, lo_n, hi_n;
        bit sep;
        b = dir_bkt[h & dmask(gdepth)];
        idx = lookup(b, h);
        n = 0;
        free_i = -1;
        sep = 0;
        if (idx >= 0) begin
            slot_v[idx] = val;
            return 0;
        end
        for (int s = 0; s < ehtbl_pkg::MAX_SLOTS; s++) begin
            if (slot_used[b*ehtbl_pkg::MAX_SLOTS+s]) begin
                ek[n] = slot_k[b*ehtbl_pkg::MAX_SLOTS+s];
                ev[n] = slot_v[b*ehtbl_pkg::MAX_SLOTS+s];
                n++;
            end else if (free_i < 0) begin
                free_i = b*ehtbl_pkg::MAX_SLOTS + s;
            end
        end
        cap = (slots_reg < 1) ? 1 :
              (slots_reg > ehtbl_pkg::MAX_SLOTS) ? ehtbl_pkg::MAX_SLOTS : slots_reg;
        if (n + 1 <= cap && free_i >= 0) begin
            slot_k[free_i] = h;
            slot_v[free_i] = val;
            slot_used[free_i] = 1;
            return 0;
        end
        ek[n] = h;
        ev[n] = val;
        n++;
        // first hash bit that separates the overflowing pairs
        ld0 = bkt_depth[b];
        p = ld0;
        while (p < ehtbl_pkg::MAX_DEPTH && !sep) begin
            for (int s = 1; s < n; s++) begin
                if (ek[s][p] != ek[0][p]) sep = 1;
            end
            if (!sep) p++;
        end
        if (!sep) return 1;
        while (gdepth < p + 1) begin
            for (int i = 0; i < (1 << gdepth); i++) dir_bkt[i + (1 << gdepth)] = dir_bkt[i];
            gdepth++;
        end
        // empty buckets for the non-separating bits
        base = ek[0] & dmask(ld0);
        for (int d = ld0; d < p; d++) begin
            v = ek[0][d];
            nb = nbuckets++;
            wipe_bucket(nb);
            bkt_depth[nb] = d + 1;
            redirect(base | ((v ^ 1) << d), d + 1, nb);
            base |= v << d;
        end
        nb = nbuckets++;
        wipe_bucket(nb);
        bkt_depth[nb] = p + 1;
        bkt_depth[b] = p + 1;
        redirect(base | (1 << p), p + 1, nb);
        wipe_bucket(b);
        lo_n = 0;
        hi_n = 0;
        for (int s = 0; s < n; s++) begin
            if (ek[s][p]) idx = nb*ehtbl_pkg::MAX_SLOTS + hi_n++;
            else idx = b*ehtbl_pkg::MAX_SLOTS + lo_n++;
            slot_k[idx] = ek[s];
            slot_v[idx] = ev[s];
            slot_used[idx] = 1;
        end
        return 0;
    endfunction

    function automatic t_rsp apply_request(ehtbl_pkg::t_action act,
                                           logic [ehtbl_pkg::KEY_W-1:0] h,
                                           logic [ehtbl_pkg::VAL_W-1:0] val,
                                           logic [ehtbl_pkg::IDX_W-1:0] di);
        t_rsp r;
        int b, s;
        r = '0;
        b = dir_bkt[h & dmask(gdepth)];
        case (act)
            ehtbl_pkg::ACT_FIND: begin
                s = lookup(b, h);
                if (s >= 0) begin
                    r.hit = 1;
                    r.value_out = slot_v[s];
                end
            end
            ehtbl_pkg::ACT_INSERT: begin
                r.status = store_pair(h, val);
            end
            ehtbl_pkg::ACT_REMOVE: begin
                s = lookup(b, h);
                if (s >= 0) begin
                    r.hit = 1;
                    slot_used[s] = 0;
                end
            end
            default: begin
                if (int'(di) < (1 << gdepth))
                    r.local_depth = ehtbl_pkg::LDO_W'(bkt_depth[dir_bkt[di]]);
                else r.local_depth = '1;
            end
        endcase
        r.global_depth = ehtbl_pkg::GD_W'(gdepth);
        r.bucket_count = ehtbl_pkg::BC_W'(nbuckets);
        return r;
    endfunction

    // prediction and comparison
    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp got_r;
        t_rsp pred_r;
        if (!i_rst_n) begin
            clear_table();
            pending_rsp.delete();
        end else begin
            if (i_cfg_we) slots_reg = int'(i_cfg_wdata);
            if (i_req.valid && i_req.ready) begin
                pred_r = apply_request(ehtbl_pkg::t_action'(i_req.action), i_req.key,
                                       i_req.value_in, i_req.dir_index);
                pending_rsp = {pending_rsp, pred_r};
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got_r = {i_rsp.hit, i_rsp.value_out, i_rsp.status, i_rsp.local_depth,
                         i_rsp.global_depth, i_rsp.bucket_count};
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected response, got %h", $time, got_r);
                    o_fail_count++;
                end else begin
                    exp_r = pending_rsp.pop_front();
                    if (got_r.hit !== exp_r.hit) begin
                        $display("%0t: hit exp %0d got %0d", $time, exp_r.hit, got_r.hit);
                        o_fail_count++;
                    end
                    if (got_r.value_out !== exp_r.value_out) begin
                        $display("%0t: value_out exp %h got %h", $time,
                                 exp_r.value_out, got_r.value_out);
                        o_fail_count++;
                    end
                    if (got_r.status !== exp_r.status) begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                                 got_r.status);
                        o_fail_count++;
                    end
                    if (got_r.local_depth !== exp_r.local_depth) begin
                        $display("%0t: local_depth exp %h got %h", $time,
                                 exp_r.local_depth, got_r.local_depth);
                        o_fail_count++;
                    end
                    if (got_r.global_depth !== exp_r.global_depth) begin
                        $display("%0t: global_depth exp %0d got %0d", $time,
                                 exp_r.global_depth, got_r.global_depth);
                        o_fail_count++;
                    end
                    if (got_r.bucket_count !== exp_r.bucket_count) begin
                        $display("%0t: bucket_count exp %0d got %0d", $time,
                                 exp_r.bucket_count, got_r.bucket_count);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT = 6000;
    localparam int RAND_ITEMS = 528;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [ehtbl_pkg::CFG_W-1:0] i_cfg_wdata;
    int                          fail_count;
    int                          req_count;
    int                          rsp_count;
    int                          quiet_cycles;
    int                          idle_pct;
    int                          stall_pct;
    int                          refused_count;
    logic [ehtbl_pkg::KEY_W-1:0] stored_keys[$];

    ehtbl_req_if req_ch ();
    ehtbl_rsp_if rsp_ch ();

    extendible_hash_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    ehtbl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count)
    );

    initial i_clk = 0;
    always #4 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // request counts, refusals and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) req_count <= req_count + 1;
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_count <= rsp_count + 1;
                if (rsp_ch.status) refused_count <= refused_count + 1;
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_request(ehtbl_pkg::t_action act, logic [ehtbl_pkg::KEY_W-1:0] k,
                                logic [ehtbl_pkg::VAL_W-1:0] v,
                                logic [ehtbl_pkg::IDX_W-1:0] di);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.key       <= k;
        req_ch.value_in  <= v;
        req_ch.dir_index <= di;
        do @(posedge i_clk); while (!req_ch.ready);
        if (act == ehtbl_pkg::ACT_INSERT) stored_keys = {stored_keys, k};
    endtask

    // sender holds off until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_count < req_count) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slots(logic [ehtbl_pkg::CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // keys crowd a few low bytes so buckets fill and split deep
    function automatic logic [ehtbl_pkg::KEY_W-1:0] pick_key();
        logic [ehtbl_pkg::KEY_W-1:0] k;
        k = $urandom;
        if ($urandom_range(99) < 60) begin
            k[7:0] = 8'($urandom_range(15) * 17);
            if ($urandom_range(1)) k[ehtbl_pkg::KEY_W-1:8] = 24'($urandom_range(7));
        end
        return k;
    endfunction

    task automatic random_request();
        logic [ehtbl_pkg::KEY_W-1:0] k;
        logic [ehtbl_pkg::IDX_W-1:0] di;
        int r;
        r = $urandom_range(99);
        k = pick_key();
        if (stored_keys.size() > 0 && $urandom_range(1))
            k = stored_keys[$urandom_range(stored_keys.size() - 1)];
        di = $urandom_range(1) ? ehtbl_pkg::IDX_W'($urandom)
                               : ehtbl_pkg::IDX_W'($urandom_range(15));
        if (r < 45)      send_request(ehtbl_pkg::ACT_INSERT, k, $urandom, di);
        else if (r < 65) send_request(ehtbl_pkg::ACT_FIND, k, $urandom, di);
        else if (r < 80) send_request(ehtbl_pkg::ACT_REMOVE, k, $urandom, di);
        else             send_request(ehtbl_pkg::ACT_QUERY, k, $urandom, di);
    endtask

    logic [ehtbl_pkg::CFG_W-1:0] slot_plan[6] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};

    initial begin
        req_ch.valid     = 1'b0;
        req_ch.action    = ehtbl_pkg::ACT_FIND;
        req_ch.key       = '0;
        req_ch.value_in  = '0;
        req_ch.dir_index = '0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = ehtbl_pkg::SLOTS_RESET;
        idle_pct         = 0;
        stall_pct        = 0;
        i_rst_n          = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, overwrite, hit and miss, depth limit
        send_request(ehtbl_pkg::ACT_FIND, 32'h0000_0000, 32'h0, 8'd0);
        send_request(ehtbl_pkg::ACT_QUERY, 32'h0, 32'h0, 8'd0);
        send_request(ehtbl_pkg::ACT_QUERY, 32'h0, 32'h0, 8'd255);
        send_request(ehtbl_pkg::ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
        send_request(ehtbl_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0);
        send_request(ehtbl_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_request(ehtbl_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'h1234_5678, 8'd0);
        send_request(ehtbl_pkg::ACT_FIND, 32'h7FFF_FFFF, 32'h0, 8'd0);
        send_request(ehtbl_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_request(ehtbl_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_request(ehtbl_pkg::ACT_FIND, 32'hFFFF_FFFF, 32'h0, 8'd0);
        for (int i = 0; i < 6; i++)
            send_request(ehtbl_pkg::ACT_INSERT, 32'h0000_00AA | (i << 8), i, 8'd0);
        send_request(ehtbl_pkg::ACT_INSERT, 32'h0000_0002, 32'h5, 8'd0);
        send_request(ehtbl_pkg::ACT_QUERY, 32'h0, 32'h0, 8'd1);
        send_request(ehtbl_pkg::ACT_QUERY, 32'h0, 32'h0, 8'hAA);
        send_request(ehtbl_pkg::ACT_QUERY, 32'h0, 32'h0, 8'd128);
        send_request(ehtbl_pkg::ACT_FIND, 32'h0000_01AA, 32'h0, 8'd0);
        drain();

        // random phases, one slot setting each, rotating idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            write_slots(slot_plan[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (int i = 0; i < RAND_ITEMS / 6; i++) random_request();
            drain();
        end

        $display("covered %0d requests, %0d refused inserts, six bucket size settings",
                 req_count, refused_count);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ehtbl_pkg.sv
hw/rtl/ehtbl_if.sv
hw/rtl/ehtbl_ram.sv
hw/rtl/ehtbl_eval.sv
hw/rtl/extendible_hash_table.sv
tb/ehtbl_checker.sv
tb/tb_top.sv
